// ===== rtl/core/qtea_pkg.sv =====
// ----------------------------------------------------------------------------
// qtea_pkg: shared constants for the quaternion to Euler angle core
// Widths, CORDIC angle table and pipeline depths used by the core and its
// CORDIC units.
// ----------------------------------------------------------------------------
package qtea_pkg;

  localparam int QUAT_W      = 16;
  localparam int PRODUCT_W   = 2 * QUAT_W;
  localparam int PROD_W      = 35;   // sums of products, 28 fraction bits
  localparam int CORDIC_W    = 38;   // CORDIC x/y datapath
  localparam int ANG_W       = 34;   // angle accumulator, 2^32 = one turn
  localparam int ANGLE_OUT_W = 16;
  localparam int CLAMP_W     = 30;   // clamped asin argument
  localparam int SQ_W        = 58;   // radicand and remainder
  localparam int ROOT_W      = 29;   // square root result
  localparam int SQ_STAGES   = ROOT_W;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int USED_STAGES   = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  // CORDIC unit: pre-rotation register, one register per iteration, output register
  localparam int CORDIC_LAT = USED_STAGES + 2;
  // roll path runs through the square root, pitch and yaw wait for it
  localparam int ALIGN_LAT  = SQ_STAGES + 2;
  localparam int LATENCY    = 4 + SQ_STAGES + CORDIC_LAT;

  localparam logic signed [PROD_W-1:0]  ONE_Q28      = 35'sd268435456;
  localparam logic signed [ANG_W-1:0]   QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0]   HALF_TURN    = 34'sd2147483648;
  localparam logic signed [ANG_W-1:0]   ROUND_HALF   = 34'sd32768;
  localparam logic [SQ_W-1:0]           ONE_SQ       = 58'd72057594037927936;

  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

endpackage

// ===== rtl/core/qtea_cordic.sv =====
// ----------------------------------------------------------------------------
// qtea_cordic: pipelined vectoring CORDIC atan2
// Quadrant pre-rotation, one register stage per iteration, and rounding of
// the accumulated angle to a 16-bit binary angle.
// ----------------------------------------------------------------------------
module qtea_cordic (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  input  logic signed [qtea_pkg::PROD_W-1:0]       in_y,
  input  logic signed [qtea_pkg::PROD_W-1:0]       in_x,
  output logic                                     out_valid,
  output logic [qtea_pkg::ANGLE_OUT_W-1:0]         out_angle
);

  localparam int N  = qtea_pkg::USED_STAGES;
  localparam int CW = qtea_pkg::CORDIC_W;
  localparam int AW = qtea_pkg::ANG_W;

  logic signed [CW-1:0] xs [N+1];
  logic signed [CW-1:0] ys [N+1];
  logic signed [AW-1:0] zs [N+1];
  logic                 hold [N+1];
  logic                 vld [N+1];

  logic signed [CW-1:0] x_in, y_in, x_pre, y_pre;
  logic signed [AW-1:0] z_pre, z_rnd;
  logic                 hold_pre;

  assign x_in = CW'(in_x);
  assign y_in = CW'(in_y);

  // the y axis and the negative x axis resolve at once; left half-plane rotates by a quarter turn
  always_comb begin
    hold_pre = 1'b0;
    x_pre    = x_in;
    y_pre    = y_in;
    z_pre    = '0;
    if (x_in == 0) begin
      hold_pre = 1'b1;
      if (y_in > 0) z_pre = qtea_pkg::QUARTER_TURN;
      else if (y_in < 0) z_pre = -qtea_pkg::QUARTER_TURN;
    end else if (y_in == 0 && x_in < 0) begin
      hold_pre = 1'b1;
      z_pre    = qtea_pkg::HALF_TURN;
    end else if (x_in < 0) begin
      if (y_in >= 0) begin
        x_pre = y_in;
        y_pre = -x_in;
        z_pre = qtea_pkg::QUARTER_TURN;
      end else begin
        x_pre = -y_in;
        y_pre = x_in;
        z_pre = -qtea_pkg::QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= in_valid;
    xs[0]   <= x_pre;
    ys[0]   <= y_pre;
    zs[0]   <= z_pre;
    hold[0] <= hold_pre;
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    logic signed [AW-1:0] atan_i;
    assign dx     = ys[i] >>> i;
    assign dy     = xs[i] >>> i;
    assign atan_i = signed'(AW'(qtea_pkg::ATAN_TAB[i]));

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
      hold[i+1] <= hold[i];
      if (hold[i]) begin
        xs[i+1] <= xs[i];
        ys[i+1] <= ys[i];
        zs[i+1] <= zs[i];
      end else if (ys[i] >= 0) begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + atan_i;
      end else begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - atan_i;
      end
    end
  end

  assign z_rnd = zs[N] + qtea_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= vld[N];
    out_angle <= z_rnd[31:16];
  end

endmodule

// ===== rtl/core/quaternion_to_euler_angles_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core: quaternion to Euler angle converter
// Converts a Q1.14 quaternion to pitch, roll and yaw binary angles.
// ----------------------------------------------------------------------------
// A quaternion is taken in every cycle that start is high; busy stays low, so
// the block never refuses a beat. Each result appears on the angle ports for
// one cycle with done high, in input order. The roll path sets the latency: a
// 29-stage bit-per-stage square root followed by a pipelined CORDIC. Pitch and
// yaw finish early and are held in delay lines to line up with roll. There is
// no state between beats.
module quaternion_to_euler_angles_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [qtea_pkg::QUAT_W-1:0]  quat_w,
  input  logic signed [qtea_pkg::QUAT_W-1:0]  quat_x,
  input  logic signed [qtea_pkg::QUAT_W-1:0]  quat_y,
  input  logic signed [qtea_pkg::QUAT_W-1:0]  quat_z,
  output logic                                done,
  output logic signed [15:0]                  pitch_angle,
  output logic signed [15:0]                  roll_angle,
  output logic signed [15:0]                  yaw_angle,
  output logic                                roll_saturated
);

  localparam int PW  = qtea_pkg::PRODUCT_W;
  localparam int SW  = qtea_pkg::PROD_W;
  localparam int CLW = qtea_pkg::CLAMP_W;
  localparam int QW  = qtea_pkg::SQ_W;
  localparam int RW  = qtea_pkg::ROOT_W;
  localparam int SQN = qtea_pkg::SQ_STAGES;
  localparam int AL  = qtea_pkg::ALIGN_LAT;
  localparam int CL  = qtea_pkg::CORDIC_LAT;
  localparam int OW  = qtea_pkg::ANGLE_OUT_W;

  assign busy = 1'b0;

  // stage 1: products
  logic signed [PW-1:0] p_yz, p_wx, p_xx, p_yy, p_xy, p_wz, p_zz, p_wy, p_xz;
  logic v1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    p_yz <= quat_y * quat_z;
    p_wx <= quat_w * quat_x;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_xy <= quat_x * quat_y;
    p_wz <= quat_w * quat_z;
    p_zz <= quat_z * quat_z;
    p_wy <= quat_w * quat_y;
    p_xz <= quat_x * quat_z;
  end

  // stage 2: sums, clamp of the asin argument
  logic signed [SW-1:0]  s_raw;
  logic signed [SW-1:0]  pitch_y2, pitch_x2, yaw_y2, yaw_x2;
  logic signed [CLW-1:0] s_cl_next, s2;
  logic                  sat_next, sat2, v2;

  assign s_raw = (SW'(p_wy) - SW'(p_xz)) <<< 1;

  always_comb begin
    sat_next  = 1'b0;
    s_cl_next = CLW'(s_raw);
    if (s_raw > qtea_pkg::ONE_Q28) begin
      sat_next  = 1'b1;
      s_cl_next = CLW'(qtea_pkg::ONE_Q28);
    end else if (s_raw < -qtea_pkg::ONE_Q28) begin
      sat_next  = 1'b1;
      s_cl_next = CLW'(-qtea_pkg::ONE_Q28);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    pitch_y2 <= (SW'(p_yz) + SW'(p_wx)) <<< 1;
    pitch_x2 <= qtea_pkg::ONE_Q28 - ((SW'(p_xx) + SW'(p_yy)) <<< 1);
    yaw_y2   <= (SW'(p_xy) + SW'(p_wz)) <<< 1;
    yaw_x2   <= qtea_pkg::ONE_Q28 - ((SW'(p_yy) + SW'(p_zz)) <<< 1);
    s2       <= s_cl_next;
    sat2     <= sat_next;
  end

  // stage 3: square of the clamped argument
  logic signed [2*CLW-1:0] s_sq;
  logic signed [CLW-1:0]   s3;
  logic                    sat3, v3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    s_sq <= s2 * s2;
    s3   <= s2;
    sat3 <= sat2;
  end

  // stage 4 is the first square root register: radicand 1 - s^2
  logic [QW-1:0]         rem   [SQN+1];
  logic [RW-1:0]         root  [SQN+1];
  logic signed [CLW-1:0] s_d   [SQN+1];
  logic                  sat_d [SQN+1];
  logic                  v_d   [SQN+1];

  always_ff @(posedge clk) begin
    if (rst) v_d[0] <= 1'b0;
    else v_d[0] <= v3;
    rem[0]   <= qtea_pkg::ONE_SQ - s_sq[QW-1:0];
    root[0]  <= '0;
    s_d[0]   <= s3;
    sat_d[0] <= sat3;
  end

  // one result bit per stage, most significant first
  for (genvar j = 0; j < SQN; j++) begin : g_sqrt
    localparam int K = SQN - 1 - j;
    logic [QW-1:0] trial;
    assign trial = (QW'(root[j]) << (K + 1)) | (QW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) v_d[j+1] <= 1'b0;
      else v_d[j+1] <= v_d[j];
      s_d[j+1]   <= s_d[j];
      sat_d[j+1] <= sat_d[j];
      if (rem[j] >= trial) begin
        rem[j+1]  <= rem[j] - trial;
        root[j+1] <= root[j] | (RW'(1) << K);
      end else begin
        rem[j+1]  <= rem[j];
        root[j+1] <= root[j];
      end
    end
  end

  // CORDIC units
  logic          pitch_vld, yaw_vld, roll_vld;
  logic [OW-1:0] pitch_a, yaw_a, roll_a;

  qtea_cordic u_pitch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_y      (pitch_y2),
    .in_x      (pitch_x2),
    .out_valid (pitch_vld),
    .out_angle (pitch_a)
  );

  qtea_cordic u_yaw (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_y      (yaw_y2),
    .in_x      (yaw_x2),
    .out_valid (yaw_vld),
    .out_angle (yaw_a)
  );

  qtea_cordic u_roll (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_d[SQN]),
    .in_y      (SW'(s_d[SQN])),
    .in_x      (SW'(root[SQN])),
    .out_valid (roll_vld),
    .out_angle (roll_a)
  );

  // hold pitch and yaw until roll catches up
  logic [OW-1:0] pitch_dly [AL];
  logic [OW-1:0] yaw_dly   [AL];
  logic          pv_dly    [AL];
  logic          sat_dly   [CL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AL; i++) pv_dly[i] <= 1'b0;
    end else begin
      pv_dly[0] <= pitch_vld & yaw_vld;
      for (int i = 1; i < AL; i++) pv_dly[i] <= pv_dly[i-1];
    end
    pitch_dly[0] <= pitch_a;
    yaw_dly[0]   <= yaw_a;
    for (int i = 1; i < AL; i++) begin
      pitch_dly[i] <= pitch_dly[i-1];
      yaw_dly[i]   <= yaw_dly[i-1];
    end
    sat_dly[0] <= sat_d[SQN];
    for (int i = 1; i < CL; i++) sat_dly[i] <= sat_dly[i-1];
  end

  assign done           = roll_vld;
  assign pitch_angle    = pitch_dly[AL-1];
  assign yaw_angle      = yaw_dly[AL-1];
  assign roll_angle     = roll_a;
  assign roll_saturated = sat_dly[CL-1];

  // pitch and yaw beats line up with roll
  a_align: assert property (@(posedge clk) disable iff (rst)
    pv_dly[AL-1] == roll_vld)
    else $error("pitch/yaw beat out of step with roll");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(qtea_pkg::LATENCY) done)
    else $error("result beat missing at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##(qtea_pkg::LATENCY) !done)
    else $error("result beat without a start beat");

  a_sat_angle: assert property (@(posedge clk) disable iff (rst)
    (done && roll_saturated) |-> (roll_angle == 16'sd16384 || roll_angle == -16'sd16384))
    else $error("clamped roll is not a quarter turn");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for quaternion_to_euler_angles_core
// Drives quaternions through the start/busy handshake with random gaps,
// predicts the three binary angles and the clamp flag with a bit-exact CORDIC
// model, and checks every done beat against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_RANDOM   = 740;
  localparam int TAIL_WAIT  = qtea_pkg::LATENCY + 20;
  localparam int CYCLE_CAP  = 400000;
  localparam int N_STAGES   = qtea_pkg::USED_STAGES;

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] yaw;
    logic               sat;
  } angles_t;

  // Bit-exact angle predictor and in-order store of expected angle sets.
  class angle_scoreboard;
    angles_t pending[$];
    int      mismatches;
    int      checked;

    function longint vec_angle(longint vy, longint vx);
      longint acc, tmp, dx, dy;
      acc = 0;
      if (vx == 0) begin
        if (vy > 0) return 64'sd1 <<< 30;
        if (vy < 0) return -(64'sd1 <<< 30);
        return 0;
      end
      if (vy == 0 && vx < 0) return 64'sd1 <<< 31;
      if (vx < 0) begin
        tmp = vx;
        if (vy >= 0) begin
          vx = vy; vy = -tmp; acc = 64'sd1 <<< 30;
        end else begin
          vx = -vy; vy = tmp; acc = -(64'sd1 <<< 30);
        end
      end
      for (int i = 0; i < N_STAGES; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx += dx; vy -= dy; acc += longint'(qtea_pkg::ATAN_TAB[i]);
        end else begin
          vx -= dx; vy += dy; acc -= longint'(qtea_pkg::ATAN_TAB[i]);
        end
      end
      return acc;
    endfunction

    function logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function logic signed [15:0] to_bam(longint a);
      logic [63:0] u;
      u = (a + 64'sd32768) >>> 16;
      return u[15:0];
    endfunction

    function void note_quat(logic signed [15:0] w, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z);
      longint  one, py, px, yy, yx, s, c;
      angles_t e;
      one = 64'sd1 <<< 28;
      py = 2 * (longint'(y) * z + longint'(w) * x);
      px = one - 2 * (longint'(x) * x + longint'(y) * y);
      yy = 2 * (longint'(x) * y + longint'(w) * z);
      yx = one - 2 * (longint'(y) * y + longint'(z) * z);
      s  = 2 * (longint'(w) * y - longint'(x) * z);
      e.sat = 1'b0;
      if (s > one) begin
        s = one; e.sat = 1'b1;
      end else if (s < -one) begin
        s = -one; e.sat = 1'b1;
      end
      c = root_floor(one * one - s * s);
      e.pitch = to_bam(vec_angle(py, px));
      e.roll  = to_bam(vec_angle(s, c));
      e.yaw   = to_bam(vec_angle(yy, yx));
      pending.push_back(e);
    endfunction

    function void check_angles(angles_t got);
      angles_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result p=%0d r=%0d y=%0d s=%0b",
                   got.pitch, got.roll, got.yaw, got.sat);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.pitch !== e.pitch || got.roll !== e.roll ||
          got.yaw !== e.yaw || got.sat !== e.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp p=%0d r=%0d y=%0d s=%0b got p=%0d r=%0d y=%0d s=%0b",
                   checked, e.pitch, e.roll, e.yaw, e.sat,
                   got.pitch, got.roll, got.yaw, got.sat);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic done;
  logic signed [15:0] pitch_angle, roll_angle, yaw_angle;
  logic roll_saturated;

  angle_scoreboard sb = new();
  int cycles = 0;
  int beats  = 0;
  int clamps = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_to_euler_angles_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .done(done), .pitch_angle(pitch_angle), .roll_angle(roll_angle),
    .yaw_angle(yaw_angle), .roll_saturated(roll_saturated)
  );

  // Note accepted beats and check results at the same edge the block sees.
  always @(posedge clk) begin
    angles_t got;
    cycles <= cycles + 1;
    if (!rst && start && !busy) begin
      sb.note_quat(quat_w, quat_x, quat_y, quat_z);
      beats <= beats + 1;
    end
    if (!rst && done) begin
      got.pitch = pitch_angle; got.roll = roll_angle;
      got.yaw = yaw_angle; got.sat = roll_saturated;
      if (roll_saturated) clamps <= clamps + 1;
      sb.check_angles(got);
    end
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // Drop start for the idle cycles, then hold the beat until it is accepted.
  task automatic send_quat(input logic signed [15:0] w, x, y, z);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    do @(posedge clk); while (busy);
  endtask

  // Unit range most of the time (at times exactly +1 or -1), full 16-bit pattern otherwise.
  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom());
      1: return $urandom_range(0, 3) == 0 ? -16'sd16384 : 16'sd16384;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  task automatic send_unit_quat();
    real a, ux, uy, uz, n;
    a = ($urandom() % 62832) / 10000.0;
    ux = $urandom_range(0, 2000) - 1000.0;
    uy = $urandom_range(0, 2000) - 1000.0;
    uz = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(ux * ux + uy * uy + uz * uz) + 1e-9;
    send_quat(16'($rtoi(16384.0 * $cos(a / 2))),
              16'($rtoi(16384.0 * $sin(a / 2) * ux / n)),
              16'($rtoi(16384.0 * $sin(a / 2) * uy / n)),
              16'($rtoi(16384.0 * $sin(a / 2) * uz / n)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // identity, axis half turns, zero vector, quarter turns, extremes, clamp both ways
    send_quat(16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 0, 0);
    send_quat(-16384, -16384, -16384, -16384);
    send_quat(16384, 16384, 16384, 16384);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(16384, 0, 16384, 0);
    send_quat(16384, 0, -16384, 0);
    send_quat(11585, 11585, 0, 0);
    send_quat(11585, 0, 0, 11585);
    send_quat(11585, -11585, 0, 0);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_quat(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_quat(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);

    // hold off until the pipeline drains
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 1)) send_unit_quat();
      else send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      // bursts of random quaternions, each still sent with a random gap
      if (i % 100 == 50)
        repeat (20) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("tb: %0d quaternions sent, %0d results checked, %0d clamped roll",
             beats, sb.checked, clamps);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("mismatches: %0d, left pending: %0d", sb.mismatches, sb.pending.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/qtea_pkg.sv
rtl/core/qtea_cordic.sv
rtl/core/quaternion_to_euler_angles_core.sv
tb/tb_top.sv
